// ----- rtl/core/cps_pkg.sv -----
`timescale 1ns / 1ps

package cps_pkg;

    // display geometry
    localparam int LINE_COUNT  = 6;
    localparam int DIGIT_COUNT = 4;
    localparam int GLYPH_COUNT = 19;
    localparam int SEG_COUNT   = 7;
    localparam int ICON_COUNT  = 8;

    // register file
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CODE_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_DIVIDER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT0_CODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT1_CODE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT2_CODE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT3_CODE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ICON_MASK    = 3'd5;

    localparam logic [CODE_W-1:0] CODE_BLANK = 5'd18;

    typedef logic [LINE_COUNT-1:0]   line_vec_t;
    typedef logic [2:0]              line_num_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
    typedef logic [CODE_W-1:0]       code_t;
    typedef logic [DIGIT_COUNT-1:0][CODE_W-1:0] code_vec_t;
    typedef logic [ICON_COUNT-1:0]   icon_mask_t;

    // segment masks, bit 0 = a ... bit 6 = g
    localparam logic [SEG_COUNT-1:0] GLYPH_SEGMENTS [GLYPH_COUNT] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h08, 7'h7C, 7'h38, 7'h3E, 7'h79, 7'h73, 7'h76, 7'h77, 7'h00
    };

    // led pair per digit and segment: anode line in high nibble, cathode in low
    localparam logic [7:0] SEGMENT_PAIRS [DIGIT_COUNT][SEG_COUNT] = '{
        '{8'h00, 8'h43, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h21, 8'h31, 8'h41, 8'h51, 8'h61, 8'h32, 8'h42},
        '{8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h52, 8'h62},
        '{8'h23, 8'h24, 8'h25, 8'h26, 8'h34, 8'h35, 8'h36}
    };

    localparam logic [7:0] ICON_PAIRS [8] = '{
        8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // cathode line for a lit led pair when its anode matches
    function automatic line_vec_t pair_cathode(input logic [7:0] pair, input line_num_t anode);
        logic [3:0] hi;
        logic [3:0] lo;
        line_vec_t  bits;
        hi   = pair[7:4];
        lo   = pair[3:0];
        bits = '0;
        if (hi != 4'd0 && hi == {1'b0, anode} && lo >= 4'd1 && lo <= 4'd6)
        begin
            bits = line_vec_t'(1) << (lo - 4'd1);
        end
        return bits;
    endfunction

    // all cathodes to pull low for one anode line
    function automatic line_vec_t cathode_lines(input line_num_t anode,
                                                input code_vec_t codes,
                                                input icon_mask_t icons);
        line_vec_t          low;
        logic [SEG_COUNT-1:0] segs;
        low = '0;
        for (int i = 0; i < ICON_COUNT && i < 8; i++)
        begin
            if (icons[i])
            begin
                low = low | pair_cathode(ICON_PAIRS[i], anode);
            end
        end
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            segs = GLYPH_SEGMENTS[codes[d]];
            for (int s = 0; s < SEG_COUNT; s++)
            begin
                if (segs[s])
                begin
                    low = low | pair_cathode(SEGMENT_PAIRS[d][s], anode);
                end
            end
        end
        return low;
    endfunction

endpackage

// ----- rtl/core/charlieplex_segment_scanner_top.sv -----
`timescale 1ns / 1ps

// Charlieplexed scanner for four seven-segment digits and icons on six lines.
// Input channel: in_valid/in_stall carries one tick per transaction with the
// asleep flag. A prescaler counts ticks; every scan_divider-th tick, unless
// asleep, one scan step is taken and one output transaction is produced.
// Output channel: out_valid/out_stall carries drive_enable, drive_level and
// anode_line for that step. Divider zero ignores ticks entirely.
// The step decoded at the accepting edge appears in the output register on the
// next cycle. Ticks are taken at one per cycle while in_stall is low; the
// glyph and pair tables are decoded in a single pass ahead of the output
// register.
// When the receiver stalls, the output register holds its transaction and
// in_stall is raised only while that register is full and stalled, so a new
// tick is taken in the same cycle the previous result drains.
// Reset: scan_divider 1, digit codes blank, icon mask 0, scan line 1,
// prescaler 0, no output pending. The user must write configuration through
// cfg_write_enable/cfg_index/cfg_data while the block is idle; this is not enforced.
module charlieplex_segment_scanner_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_enable,
    input  cps_pkg::cfg_index_t   cfg_index,
    input  cps_pkg::cfg_data_t    cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  asleep,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cps_pkg::line_vec_t    drive_enable,
    output cps_pkg::line_vec_t    drive_level,
    output cps_pkg::line_num_t    anode_line
);
    import cps_pkg::*;

    cfg_data_t   scan_divider_reg;
    code_vec_t   digit_code_reg;
    icon_mask_t  icon_mask_reg;
    line_num_t   scan_line_reg;
    line_num_t   scan_line_next;
    cfg_data_t   prescale_count_reg;
    cfg_data_t   prescale_count_next;
    cfg_data_t   prescale_inc;
    code_t       code_wrapped;
    logic        in_accept;
    logic        step_fire;
    line_vec_t   anode_bit;
    line_vec_t   low_lines;

    logic        out_valid_reg;
    logic        out_valid_next;
    line_vec_t   drive_enable_reg;
    line_vec_t   drive_level_reg;
    line_num_t   anode_line_reg;

    // handshake: accept when the output slot is empty or draining
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // written digit code folded into the glyph range
    assign code_wrapped = (cfg_data[CODE_W-1:0] >= code_t'(GLYPH_COUNT))
                        ? cfg_data[CODE_W-1:0] - code_t'(GLYPH_COUNT)
                        : cfg_data[CODE_W-1:0];

    // prescaler and scan step decision
    always_comb
    begin
        prescale_inc        = prescale_count_reg + cfg_data_t'(1);
        prescale_count_next = prescale_count_reg;
        scan_line_next      = scan_line_reg;
        step_fire           = 1'b0;
        if (in_accept && scan_divider_reg != '0)
        begin
            if (prescale_inc < scan_divider_reg)
            begin
                prescale_count_next = prescale_inc;
            end
            else
            begin
                prescale_count_next = '0;
                if (!asleep)
                begin
                    step_fire      = 1'b1;
                    scan_line_next = (scan_line_reg >= line_num_t'(LINE_COUNT))
                                   ? line_num_t'(1) : scan_line_reg + line_num_t'(1);
                end
            end
        end
    end

    // line drive for the current anode
    assign anode_bit = line_vec_t'(1) << (scan_line_reg - line_num_t'(1));
    assign low_lines = cathode_lines(scan_line_reg, digit_code_reg, icon_mask_reg);

    // output register occupancy
    always_comb
    begin
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_divider_reg <= cfg_data_t'(1);
            digit_code_reg   <= {DIGIT_COUNT{CODE_BLANK}};
            icon_mask_reg    <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_SCAN_DIVIDER: scan_divider_reg  <= cfg_data;
                REG_DIGIT0_CODE:  digit_code_reg[0] <= code_wrapped;
                REG_DIGIT1_CODE:  digit_code_reg[1] <= code_wrapped;
                REG_DIGIT2_CODE:  digit_code_reg[2] <= code_wrapped;
                REG_DIGIT3_CODE:  digit_code_reg[3] <= code_wrapped;
                REG_ICON_MASK:    icon_mask_reg     <= cfg_data[ICON_COUNT-1:0];
                default:          ;
            endcase
        end
    end

    // scan state; a divider write restarts the prescaler
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_line_reg      <= line_num_t'(1);
            prescale_count_reg <= '0;
        end
        else
        begin
            scan_line_reg <= scan_line_next;
            if (cfg_write_enable && cfg_index == REG_SCAN_DIVIDER)
            begin
                prescale_count_reg <= '0;
            end
            else
            begin
                prescale_count_reg <= prescale_count_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_enable_reg <= '0;
            drive_level_reg  <= '0;
            anode_line_reg   <= line_num_t'(1);
        end
        else if (step_fire)
        begin
            drive_enable_reg <= low_lines | anode_bit;
            drive_level_reg  <= anode_bit;
            anode_line_reg   <= scan_line_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_enable = drive_enable_reg;
    assign drive_level  = drive_level_reg;
    assign anode_line   = anode_line_reg;

endmodule

// ----- test/charlieplex_segment_scanner_top_test.sv -----
`timescale 1ns / 1ps

module charlieplex_segment_scanner_top_test;

    import cps_pkg::*;

    // register indexes with no register behind them
    localparam cfg_index_t REG_UNUSED_LO = 3'd6;
    localparam cfg_index_t REG_UNUSED_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 400;

    typedef struct packed {
        line_vec_t enable;
        line_vec_t level;
        line_num_t anode;
    } scan_drive_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_enable;
    cfg_index_t  cfg_index;
    cfg_data_t   cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        asleep;
    logic        out_valid;
    logic        out_stall;
    line_vec_t   drive_enable;
    line_vec_t   drive_level;
    line_num_t   anode_line;

    // scanner state as the testbench sees it
    cfg_data_t   divider_q = 8'd1;
    logic [7:0]  tick_count = 8'd0;
    code_vec_t   digit_q = {DIGIT_COUNT{CODE_BLANK}};
    icon_mask_t  icons_q = '0;
    line_num_t   scan_pos = 3'd1;

    scan_drive_t pending_drives [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          idling_on = 1'b1;

    charlieplex_segment_scanner_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .asleep           (asleep),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_enable     (drive_enable),
        .drive_level      (drive_level),
        .anode_line       (anode_line)
    );

    always #6 clk = ~clk;

    // seven-segment patterns, bit 0 = a ... bit 6 = g
    function automatic logic [6:0] glyph_segments(input code_t code);
        case (code)
            5'd0:    return 7'h3F;
            5'd1:    return 7'h06;
            5'd2:    return 7'h5B;
            5'd3:    return 7'h4F;
            5'd4:    return 7'h66;
            5'd5:    return 7'h6D;
            5'd6:    return 7'h7D;
            5'd7:    return 7'h07;
            5'd8:    return 7'h7F;
            5'd9:    return 7'h6F;
            5'd10:   return 7'h08;
            5'd11:   return 7'h7C;
            5'd12:   return 7'h38;
            5'd13:   return 7'h3E;
            5'd14:   return 7'h79;
            5'd15:   return 7'h73;
            5'd16:   return 7'h76;
            5'd17:   return 7'h77;
            default: return 7'h00;
        endcase
    endfunction

    // anode/cathode pairs of one digit, segment a in the low byte, 0 = not wired
    function automatic logic [55:0] digit_wiring(input int digit);
        case (digit)
            0:       return {8'h00, 8'h00, 8'h00, 8'h00, 8'h53, 8'h43, 8'h00};
            1:       return {8'h42, 8'h32, 8'h61, 8'h51, 8'h41, 8'h31, 8'h21};
            2:       return {8'h62, 8'h52, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12};
            default: return {8'h36, 8'h35, 8'h34, 8'h26, 8'h25, 8'h24, 8'h23};
        endcase
    endfunction

    function automatic code_t fold_code(input cfg_data_t value);
        return code_t'(int'(value[4:0]) % GLYPH_COUNT);
    endfunction

    function automatic void apply_register(input cfg_index_t idx, input cfg_data_t value);
        case (idx)
            REG_SCAN_DIVIDER:
            begin
                divider_q  = value;
                tick_count = '0;
            end
            REG_DIGIT0_CODE: digit_q[0] = fold_code(value);
            REG_DIGIT1_CODE: digit_q[1] = fold_code(value);
            REG_DIGIT2_CODE: digit_q[2] = fold_code(value);
            REG_DIGIT3_CODE: digit_q[3] = fold_code(value);
            REG_ICON_MASK:   icons_q    = value;
            default:         ;
        endcase
    endfunction

    // one tick: count the prescaler and queue the line drive it produces, if any
    function automatic void predict_scan_drive(input logic sleep_flag);
        scan_drive_t drive;
        line_vec_t   low_lines;
        line_vec_t   anode_bit;
        logic [55:0] wiring;
        logic [6:0]  segs;
        logic [7:0]  pair;
        if (divider_q == 8'd0)
        begin
            return;
        end
        tick_count = tick_count + 8'd1;
        if (tick_count < divider_q)
        begin
            return;
        end
        tick_count = '0;
        if (sleep_flag)
        begin
            return;
        end
        low_lines = '0;
        // only icon 0 has an led: anode line 6, cathode line 3
        if (icons_q[0] && scan_pos == 3'd6)
        begin
            low_lines[2] = 1'b1;
        end
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            segs   = glyph_segments(digit_q[d]);
            wiring = digit_wiring(d);
            for (int s = 0; s < SEG_COUNT; s++)
            begin
                pair = wiring[s*8 +: 8];
                if (segs[s] && pair[7:4] == {1'b0, scan_pos})
                begin
                    low_lines[line_num_t'(pair[3:0] - 4'd1)] = 1'b1;
                end
            end
        end
        anode_bit     = line_vec_t'(1) << (scan_pos - 3'd1);
        drive.enable  = low_lines | anode_bit;
        drive.level   = anode_bit;
        drive.anode   = scan_pos;
        pending_drives.push_back(drive);
        scan_pos = (scan_pos == 3'd6) ? 3'd1 : scan_pos + 3'd1;
    endfunction

    // track accepted transactions and register writes, check results
    always @(posedge clk)
    begin
        scan_drive_t predicted;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_scan_drive(asleep);
            end
            if (cfg_write_enable)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_drives.size() == 0)
                begin
                    $error("unexpected transaction: drive_enable %0h drive_level %0h anode_line %0d",
                           drive_enable, drive_level, anode_line);
                    error_count++;
                end
                else
                begin
                    predicted = pending_drives.pop_front();
                    if (drive_enable !== predicted.enable)
                    begin
                        $error("drive_enable expected %0h actual %0h",
                               predicted.enable, drive_enable);
                        error_count++;
                    end
                    if (drive_level !== predicted.level)
                    begin
                        $error("drive_level expected %0h actual %0h",
                               predicted.level, drive_level);
                        error_count++;
                    end
                    if (anode_line !== predicted.anode)
                    begin
                        $error("anode_line expected %0d actual %0d",
                               predicted.anode, anode_line);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[charlieplex_segment_scanner_top] ERROR");
            $finish;
        end
    end

    // one tick transaction, with an optional gap before it
    task automatic send_tick(input logic sleep_flag);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        asleep   <= sleep_flag;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until the block has gone idle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_digits(input cfg_data_t c0, input cfg_data_t c1,
                                input cfg_data_t c2, input cfg_data_t c3);
        write_reg(REG_DIGIT0_CODE, c0);
        write_reg(REG_DIGIT1_CODE, c1);
        write_reg(REG_DIGIT2_CODE, c2);
        write_reg(REG_DIGIT3_CODE, c3);
    endtask

    // blank display straight out of reset, with one sleeping step
    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // full scans over several glyph sets and icon masks
    task automatic test_glyph_decode();
        drain_results();
        write_digits(8'd8, 8'd8, 8'd8, 8'd8);
        write_reg(REG_ICON_MASK, 8'hFF);
        repeat (6) send_tick(1'b0);
        drain_results();
        write_digits(8'd10, 8'd11, 8'd16, 8'd13);
        write_reg(REG_ICON_MASK, 8'hFE);
        repeat (6) send_tick(1'b0);
        drain_results();
        // out-of-range code folds, unused indexes must change nothing
        write_digits(8'hFF, 8'd14, 8'd15, 8'd17);
        write_reg(REG_ICON_MASK, 8'h01);
        write_reg(REG_UNUSED_LO, 8'hA5);
        write_reg(REG_UNUSED_HI, 8'h5A);
        repeat (6) send_tick(1'b0);
    endtask

    // disabled scanning, prescaler clear on write, sleep on a step tick, max divider
    task automatic test_divider_and_sleep();
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd0);
        repeat (5) send_tick(1'b0);
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd2);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd3);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd3);
        repeat (3) send_tick(1'b0);
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd255);
        repeat (510) send_tick(1'b0);
    endtask

    // random register settings, each followed by a run of random ticks
    task automatic test_random_scan(input int item_goal);
        int        sent;
        int        run_len;
        int        sleep_pct;
        cfg_data_t divider;
        sent = 0;
        while (sent < item_goal)
        begin
            drain_results();
            idling_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       divider = 8'd0;
                1:       divider = cfg_data_t'($urandom_range(0, 255));
                2, 3:    divider = cfg_data_t'($urandom_range(4, 16));
                default: divider = cfg_data_t'($urandom_range(1, 3));
            endcase
            write_reg(REG_SCAN_DIVIDER, divider);
            for (int d = 0; d < DIGIT_COUNT; d++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    write_reg(cfg_index_t'(int'(REG_DIGIT0_CODE) + d),
                              $urandom_range(0, 1) ? cfg_data_t'($urandom_range(0, 18))
                                                   : cfg_data_t'($urandom_range(0, 255)));
                end
            end
            write_reg(REG_ICON_MASK, cfg_data_t'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          cfg_data_t'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 3))
                0:       sleep_pct = 0;
                1:       sleep_pct = 10;
                2:       sleep_pct = 50;
                default: sleep_pct = 90;
            endcase
            // a disabled scanner only ignores ticks, keep those runs short
            run_len = (divider == 8'd0) ? 8 : $urandom_range(60, 150);
            repeat (run_len) send_tick($urandom_range(0, 99) < sleep_pct);
            if (divider != 8'd0)
            begin
                sent += run_len;
            end
        end
    endtask

    // full rate on both sides, no idling
    task automatic test_back_to_back(input int item_count);
        drain_results();
        idling_on = 1'b0;
        write_reg(REG_SCAN_DIVIDER, 8'd1);
        write_digits(cfg_data_t'($urandom_range(0, 18)), cfg_data_t'($urandom_range(0, 18)),
                     cfg_data_t'($urandom_range(0, 18)), cfg_data_t'($urandom_range(0, 18)));
        write_reg(REG_ICON_MASK, cfg_data_t'($urandom_range(0, 255)));
        repeat (item_count) send_tick($urandom_range(0, 9) == 0);
        drain_results();
        write_reg(REG_SCAN_DIVIDER, 8'd2);
        repeat (item_count / 2) send_tick($urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= REG_SCAN_DIVIDER;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        asleep           <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_glyph_decode();
        test_divider_and_sleep();
        test_random_scan(950);
        test_back_to_back(160);

        drain_results();
        repeat (5) @(posedge clk);
        if (pending_drives.size() != 0)
        begin
            $error("%0d expected transactions never arrived", pending_drives.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("[charlieplex_segment_scanner_top] OK");
        end
        else
        begin
            $display("[charlieplex_segment_scanner_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cps_pkg.sv
rtl/core/charlieplex_segment_scanner_top.sv
test/charlieplex_segment_scanner_top_test.sv
